>>> rtl/core/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

  // Default CORDIC iteration count and the arctangent table depth
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS             = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SEPARATION = 2'd2;

  // Register reset values
  localparam logic [15:0] STEP_TIME_RST          = 16'd655;
  localparam logic [15:0] RADIUS_RST             = 16'd3277;
  localparam logic [15:0] INVERSE_SEPARATION_RST = 16'd13653;

  // CORDIC start value (1/gain, Q2.30) and 1/(2*pi) in Q0.32
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [31:0] INV_TWO_PI_Q32  = 32'sd683565276;

  // Multiply sequence, one code per product
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LEFT  = 4'd0;  // left wheel angle step
  localparam logic [OP_W-1:0] OP_RIGHT = 4'd1;  // right wheel angle step
  localparam logic [OP_W-1:0] OP_SUM   = 4'd2;  // r * (L + R)
  localparam logic [OP_W-1:0] OP_DIST  = 4'd3;  // distance, times dt
  localparam logic [OP_W-1:0] OP_DIFF  = 4'd4;  // r * (R - L)
  localparam logic [OP_W-1:0] OP_OMEGA = 4'd5;  // turn rate, times 1/sep
  localparam logic [OP_W-1:0] OP_TURN  = 4'd6;  // turn angle, times dt
  localparam logic [OP_W-1:0] OP_HEAD  = 4'd7;  // radians to binary angle
  localparam logic [OP_W-1:0] OP_DX    = 4'd8;  // distance times cosine
  localparam logic [OP_W-1:0] OP_DY    = 4'd9;  // distance times sine

  typedef struct packed {
    logic signed [15:0] left_command;
    logic signed [15:0] right_command;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic signed [15:0] left_velocity;
    logic signed [15:0] right_velocity;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] heading;
  } ddo_out_t;

  // Rounding shift applied to each product
  function automatic logic [4:0] ddo_op_shift(input logic [OP_W-1:0] op);
    logic [4:0] s;
    case (op)
      OP_LEFT:  s = 5'd8;
      OP_RIGHT: s = 5'd8;
      OP_SUM:   s = 5'd0;
      OP_DIST:  s = 5'd24;
      OP_DIFF:  s = 5'd0;
      OP_OMEGA: s = 5'd20;
      OP_TURN:  s = 5'd13;
      OP_HEAD:  s = 5'd19;
      OP_DX:    s = 5'd31;
      OP_DY:    s = 5'd31;
      default:  s = 5'd0;
    endcase
    return s;
  endfunction

  // atan(2^-i) as a binary angle, 2^32 = full turn
  function automatic logic signed [31:0] ddo_atan(input logic [4:0] idx);
    logic signed [31:0] a;
    case (idx)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/diff_drive_odometry.sv
// Ten products go in turn through one 34x32 multiplier (multiply, then round), beside a
// CORDIC that does one iteration per cycle; in_stall stays high until the result is
// registered, so the next request is accepted only once the last one is through.
// Reset (rst, synchronous): accumulators to zero, registers to their defaults.
`timescale 1ns / 1ps

module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ddo_pkg::ddo_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ddo_pkg::ddo_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);
  import ddo_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CNT_W = $clog2(NSTEP + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_RND  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Configuration and state
  logic [15:0]        step_time;
  logic [15:0]        radius;
  logic [15:0]        inverse_separation;
  logic signed [31:0] left_acc;
  logic signed [31:0] right_acc;
  logic signed [31:0] x_acc;
  logic signed [31:0] y_acc;
  logic [31:0]        heading_acc;

  // Sequencer and shared multiplier
  logic [1:0]         state;
  logic [OP_W-1:0]    op;
  ddo_in_t            cmd;
  logic signed [16:0] cmd_sum;
  logic signed [16:0] cmd_diff;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod;
  logic [4:0]         rshift;
  logic signed [65:0] bias;
  logic signed [65:0] rnd;
  logic signed [33:0] tmp;
  logic signed [25:0] travel;

  // Saturating accumulate
  logic signed [31:0] acc_sel;
  logic signed [34:0] sat_sum;
  logic signed [31:0] sat_res;

  // CORDIC
  logic [CNT_W-1:0]   citer;
  logic               cdone;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic               cflip;
  logic signed [32:0] hz;
  logic signed [32:0] fold_z;
  logic               fold_flip;
  logic signed [31:0] cos_v;
  logic signed [31:0] sin_v;
  logic signed [31:0] atan_v;

  logic in_fire;
  logic out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time          <= STEP_TIME_RST;
      radius             <= RADIUS_RST;
      inverse_separation <= INVERSE_SEPARATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_TIME:          step_time          <= cfg_data;
        REG_RADIUS:             radius             <= cfg_data;
        REG_INVERSE_SEPARATION: inverse_separation <= cfg_data;
        default: ;
      endcase
    end
  end

  // Heading folded into [-pi/2, pi/2]
  always_comb begin
    hz        = {heading_acc[31], heading_acc};
    fold_z    = hz;
    fold_flip = 1'b0;
    if (hz > 33'sh0_4000_0000) begin
      fold_z    = hz - 33'sh0_8000_0000;
      fold_flip = 1'b1;
    end else if (hz < -33'sh0_4000_0000) begin
      fold_z    = hz + 33'sh0_8000_0000;
      fold_flip = 1'b1;
    end
  end

  assign cdone  = (citer == CNT_W'(NSTEP));
  assign atan_v = ddo_atan(5'(citer));
  assign cos_v  = cflip ? -cx : cx;
  assign sin_v  = cflip ? -cy : cy;

  // CORDIC rotation, one iteration per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      citer <= CNT_W'(NSTEP);
    end else if (in_fire) begin
      citer <= '0;
      cx    <= CORDIC_GAIN_Q30;
      cy    <= '0;
      cz    <= fold_z[31:0];
      cflip <= fold_flip;
    end else if (!cdone) begin
      citer <= citer + 1'b1;
      if (!cz[31]) begin
        cx <= cx - (cy >>> citer);
        cy <= cy + (cx >>> citer);
        cz <= cz - atan_v;
      end else begin
        cx <= cx + (cy >>> citer);
        cy <= cy - (cx >>> citer);
        cz <= cz + atan_v;
      end
    end
  end

  assign cmd_sum  = {cmd.left_command[15], cmd.left_command}
                  + {cmd.right_command[15], cmd.right_command};
  assign cmd_diff = {cmd.right_command[15], cmd.right_command}
                  - {cmd.left_command[15], cmd.left_command};

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_LEFT: begin
        mul_a = {{18{cmd.left_command[15]}}, cmd.left_command};
        mul_b = {16'd0, step_time};
      end
      OP_RIGHT: begin
        mul_a = {{18{cmd.right_command[15]}}, cmd.right_command};
        mul_b = {16'd0, step_time};
      end
      OP_SUM: begin
        mul_a = {18'd0, radius};
        mul_b = {{15{cmd_sum[16]}}, cmd_sum};
      end
      OP_DIST: begin
        mul_a = tmp;
        mul_b = {16'd0, step_time};
      end
      OP_DIFF: begin
        mul_a = {18'd0, radius};
        mul_b = {{15{cmd_diff[16]}}, cmd_diff};
      end
      OP_OMEGA: begin
        mul_a = tmp;
        mul_b = {16'd0, inverse_separation};
      end
      OP_TURN: begin
        mul_a = tmp;
        mul_b = {16'd0, step_time};
      end
      OP_HEAD: begin
        mul_a = tmp;
        mul_b = INV_TWO_PI_Q32;
      end
      OP_DX: begin
        mul_a = {{8{travel[25]}}, travel};
        mul_b = cos_v;
      end
      OP_DY: begin
        mul_a = {{8{travel[25]}}, travel};
        mul_b = sin_v;
      end
      default: ;
    endcase
  end

  // Round to nearest, ties up, then arithmetic shift
  always_comb begin
    rshift = ddo_op_shift(op);
    bias   = (rshift == 5'd0) ? 66'sd0 : (66'sd1 <<< (rshift - 5'd1));
    rnd    = (prod + bias) >>> rshift;
  end

  // Saturating add into the selected accumulator
  always_comb begin
    case (op)
      OP_LEFT:  acc_sel = left_acc;
      OP_RIGHT: acc_sel = right_acc;
      OP_DX:    acc_sel = x_acc;
      OP_DY:    acc_sel = y_acc;
      default:  acc_sel = '0;
    endcase
    sat_sum = {{3{acc_sel[31]}}, acc_sel} + rnd[34:0];
    if (!sat_sum[34] && (sat_sum[33:31] != 3'b000)) begin
      sat_res = 32'sh7fff_ffff;
    end else if (sat_sum[34] && (sat_sum[33:31] != 3'b111)) begin
      sat_res = 32'sh8000_0000;
    end else begin
      sat_res = sat_sum[31:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_LEFT;
      left_acc    <= '0;
      right_acc   <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd   <= in_data;
            op    <= OP_LEFT;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // the pose products wait for the sine and cosine
          if (cdone || (op < OP_DX)) begin
            prod  <= mul_a * mul_b;
            state <= S_RND;
          end
        end
        S_RND: begin
          case (op)
            OP_LEFT:  left_acc    <= sat_res;
            OP_RIGHT: right_acc   <= sat_res;
            OP_SUM:   tmp         <= rnd[33:0];
            OP_DIST:  travel      <= rnd[25:0];
            OP_DIFF:  tmp         <= rnd[33:0];
            OP_OMEGA: tmp         <= rnd[33:0];
            OP_TURN:  tmp         <= rnd[33:0];
            OP_HEAD:  heading_acc <= heading_acc + rnd[31:0];
            OP_DX:    x_acc       <= sat_res;
            OP_DY:    y_acc       <= sat_res;
            default: ;
          endcase
          if (op == OP_DY) begin
            state <= S_DONE;
          end else begin
            op    <= op + 1'b1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_data.left_position  <= left_acc;
      out_data.right_position <= right_acc;
      out_data.left_velocity  <= cmd.left_command;
      out_data.right_velocity <= cmd.right_command;
      out_data.pose_x         <= x_acc;
      out_data.pose_y         <= y_acc;
      out_data.heading        <= heading_acc;
    end
  end

`ifndef ASSERT_OFF
  // An accepted request starts both the multiply sequence and the CORDIC
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_MUL) && (op == OP_LEFT) && (citer == '0))
    else $error("request accept did not start the sequence");

  // Pose products only use a finished rotation
  a_cordic_ready: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RND) && ((op == OP_DX) || (op == OP_DY))) |-> cdone)
    else $error("pose product used an unfinished CORDIC result");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_valid && out_stall) |=> (state == S_DONE) && out_valid)
    else $error("result overwritten while output stalled");

  // Iteration counter stays within the step count
  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    citer <= CNT_W'(NSTEP))
    else $error("CORDIC iteration counter out of range");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ddo_pkg::*;

  localparam int CORDIC_N = CORDIC_STEPS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  // Heading change per Q7.8 unit of (R - L) at unit dt, unit radius, unit 1/sep
  localparam longint BAM_PER_UNIT = 2670177;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ddo_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ddo_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  diff_drive_odometry #(.CORDIC_STEPS(CORDIC_N)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Odometry model state and register copies
  logic [15:0] dt_reg = STEP_TIME_RST;
  logic [15:0] radius_reg = RADIUS_RST;
  logic [15:0] inv_sep_reg = INVERSE_SEPARATION_RST;
  logic signed [31:0] left_ang = '0;
  logic signed [31:0] right_ang = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic [31:0] head_bam = '0;

  longint atan_tab [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  ddo_out_t pending_poses [$];
  ddo_out_t want;
  int fail_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_writes = 0;
  int send_idle_pct = 29;
  int stall_pct = 29;
  int hold_req = 0;

  // Round to nearest, ties toward +inf
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input longint b);
    longint s;
    s = longint'(a) + b;
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Cosine and sine of a binary angle, Q2.30
  task automatic cordic_cos_sin(input logic [31:0] ang, output longint cv,
                                output longint sv);
    longint z, x, y, nx;
    bit flip;
    int n;
    z = {32'd0, ang};
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    flip = 1'b0;
    if (z >= (longint'(1) << 31)) z -= (longint'(1) << 32);
    // fold into the right half plane
    if (z > (longint'(1) << 30)) begin
      z -= (longint'(1) << 31);
      flip = 1'b1;
    end else if (z < -(longint'(1) << 30)) begin
      z += (longint'(1) << 31);
      flip = 1'b1;
    end
    n = (CORDIC_N > 24) ? 24 : CORDIC_N;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    cv = flip ? -x : x;
    sv = flip ? -y : y;
  endtask

  // One Euler step of the wheel angles and the base pose
  task automatic advance_odometry(input ddo_in_t cmd, output ddo_out_t res);
    longint lc, rc, dt, r, inv, cv, sv, d, w, c, hstep;
    lc = cmd.left_command;
    rc = cmd.right_command;
    dt = {48'd0, dt_reg};
    r = {48'd0, radius_reg};
    inv = {48'd0, inv_sep_reg};
    left_ang = sat_add(left_ang, rnd_shift(lc * dt, 8));
    right_ang = sat_add(right_ang, rnd_shift(rc * dt, 8));
    // pose uses the heading from before this step
    cordic_cos_sin(head_bam, cv, sv);
    d = rnd_shift(r * (lc + rc) * dt, 24);
    pos_x = sat_add(pos_x, rnd_shift(d * cv, 31));
    pos_y = sat_add(pos_y, rnd_shift(d * sv, 31));
    w = rnd_shift(r * (rc - lc) * inv, 20);
    c = rnd_shift(w * dt, 13);
    hstep = rnd_shift(c * longint'(INV_TWO_PI_Q32), 19);
    head_bam = head_bam + hstep[31:0];
    res.left_position = left_ang;
    res.right_position = right_ang;
    res.left_velocity = cmd.left_command;
    res.right_velocity = cmd.right_command;
    res.pose_x = pos_x;
    res.pose_y = pos_y;
    res.heading = head_bam;
  endtask

  // Receiver: random stalls, or a counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result against the oldest expected pose
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_poses.pop_front();
        n_checked++;
        check_field("left_position", want.left_position, out_data.left_position);
        check_field("right_position", want.right_position, out_data.right_position);
        check_field("left_velocity", want.left_velocity, out_data.left_velocity);
        check_field("right_velocity", want.right_velocity, out_data.right_velocity);
        check_field("pose_x", want.pose_x, out_data.pose_x);
        check_field("pose_y", want.pose_y, out_data.pose_y);
        check_field("heading", want.heading, out_data.heading);
      end
    end
  end

  // Offer one request, with optional idle cycles first; valid stays high after
  task automatic send_cmd(input logic signed [15:0] l, input logic signed [15:0] r);
    ddo_in_t cmd;
    ddo_out_t res;
    cmd.left_command = l;
    cmd.right_command = r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_odometry(cmd, res);
    pending_poses.push_back(res);
    n_sent++;
  endtask

  // Drop valid and wait until every request has produced its pose
  task automatic end_burst();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
    case (idx)
      REG_STEP_TIME:          dt_reg = val;
      REG_RADIUS:             radius_reg = val;
      REG_INVERSE_SEPARATION: inv_sep_reg = val;
      default: ;
    endcase
  endtask

  // Only called with the block idle
  task automatic apply_settings(input logic [15:0] dt, input logic [15:0] r,
                                input logic [15:0] inv, input bit poke_unused);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom()));
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_RADIUS, r);
    write_reg(REG_INVERSE_SEPARATION, inv);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_cmd();
    logic [1:0] sel;
    sel = 2'($urandom_range(3));
    case ($urandom_range(7))
      0, 1, 2: return 16'($urandom());
      3:       return 16'(int'($urandom_range(1023)) - 512);
      4:       return (sel == 0) ? 16'sh7FFF : (sel == 1) ? 16'sh8000 :
                      (sel == 2) ? 16'sd0 : 16'shFFFF;
      default: return 16'(int'($urandom_range(8191)) - 4096);
    endcase
  endfunction

  // Field extremes, rounding ties and turns at the reset settings
  task automatic test_directed();
    send_cmd(16'sd0, 16'sd0);
    send_cmd(16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000);
    send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(16'sd1, 16'sd1);
    send_cmd(-16'sd1, -16'sd1);
    send_cmd(16'sd1, -16'sd1);
    // cmd * 655 lands exactly on a half LSB
    send_cmd(16'sd128, -16'sd128);
    send_cmd(-16'sd128, 16'sd128);
    send_cmd(16'sh5555, 16'shAAAA);
    send_cmd(16'shAAAA, 16'sh5555);
    end_burst();
  endtask

  // Zero step, zero radius, all-max, and a write to the unused index
  task automatic test_registers();
    apply_settings(16'd0, RADIUS_RST, INVERSE_SEPARATION_RST, 1'b1);
    send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sd300, 16'sd900);
    end_burst();
    apply_settings(STEP_TIME_RST, 16'd0, 16'hFFFF, 1'b0);
    send_cmd(16'sh7FFF, 16'sh7FFF);
    send_cmd(-16'sd700, 16'sd700);
    end_burst();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sd1, 16'sd0);
    end_burst();
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req = 300;
    repeat (24) send_cmd(pick_cmd(), pick_cmd());
    end_burst();
    send_idle_pct = 29;
  endtask

  // Drive the wheel and pose accumulators into both rails; no idling on either side
  task automatic test_saturation();
    logic signed [31:0] delta;
    int diff, m;
    logic signed [15:0] v;
    send_idle_pct = 0;
    stall_pct = 0;
    apply_settings(16'hFFFF, 16'hFFFF, 16'd4096, 1'b0);
    // turn to about 45 degrees so x and y both move
    delta = 32'h2000_0000 - head_bam;
    diff = int'(longint'(delta) / BAM_PER_UNIT);
    send_cmd(16'(-(diff / 2)), 16'(diff - diff / 2));
    repeat (440) begin
      v = 16'($urandom_range(32767, 32000));
      send_cmd(v, v);
    end
    repeat (880) begin
      m = $urandom_range(32768, 32000);
      v = 16'(-m);
      send_cmd(v, v);
    end
    end_burst();
    send_idle_pct = 29;
    stall_pct = 29;
  endtask

  // Random settings, each followed by a burst of mixed commands
  task automatic test_random();
    logic signed [15:0] v;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(pick_reg(), pick_reg(), pick_reg(), p == 0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          v = pick_cmd();
          send_cmd(v, v);
        end else begin
          send_cmd(pick_cmd(), pick_cmd());
        end
      end
      end_burst();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_backpressure();
    test_saturation();
    test_random();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d commands across %0d register writes, including rails,",
             n_sent, n_writes);
    $display("zero settings and a long output hold-off; %0d poses checked, %0d errors",
             n_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
